@@ rtl/core/timestamp_ring_buffer_lookup_defines.svh @@
// Assertion macros shared by the timestamp ring buffer checker.
`ifndef TIMESTAMP_RING_BUFFER_LOOKUP_DEFINES_SVH
`define TIMESTAMP_RING_BUFFER_LOOKUP_DEFINES_SVH

// Implication checked in the same cycle, off while reset is asserted.
`define TRBL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, off while reset is asserted.
`define TRBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/trbl_pkg.sv @@
// Types, codes and constants of the timestamp ring buffer lookup block.
package trbl_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam logic [6:0] CAP_RESET = 7'd64;
    localparam int CFG_INDEX_W = 2;

    // Request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_LOOK  = 2'd1;
    localparam logic [1:0] REQ_EXACT = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_MISS      = 2'd1;
    localparam logic [1:0] STAT_BELOW_LAG = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAG      = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] time_stamp;
        logic [31:0] item_payload;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] match_time;
        logic [31:0] match_payload;
        logic [6:0]  fill_count;
        logic [63:0] oldest_time;
        logic [63:0] newest_time;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD_RD,
        ST_OLD_CAP,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

@@ rtl/core/timestamp_ring_buffer_lookup.sv @@
// Top level of the timestamp ring buffer lookup block.
//
//  Channel  Signals                               Direction  Transaction
//  req      req_valid req_ready req_data          in         one request
//  rsp      rsp_valid rsp_ready rsp_data          out        one result per request
//  cfg      cfg_valid cfg_ready cfg_index cfg_data in        one register write
//
// Add and clear go straight to ST_DONE; an add into a full ring first passes ST_OLD_RD and
// ST_OLD_CAP, since the new oldest timestamp is read back from the time memory.
// Lookup and exact match walk the ring in ST_SCAN, unless a lookup is below the lag:
// the walk reads one ring entry per cycle through the single read port of the memories.
// One request is in flight at a time; req_ready is low until its result is loaded into
// the output register, which may still hold an untaken result meanwhile.
// Reset empties the ring and restores capacity 64 (clamped to DEPTH) and lag 0; the
// entry memories are not cleared, only entries written since are ever read.
module timestamp_ring_buffer_lookup #(
    parameter int DEPTH = trbl_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  trbl_pkg::req_t                       req_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output trbl_pkg::rsp_t                       rsp_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [trbl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data
);
    import trbl_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int CAP_RST_I = (int'(CAP_RESET) < DEPTH) ? int'(CAP_RESET) : DEPTH;

    // Advance a ring index, wrapping at the capacity in use.
    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] cap);
        logic [IW:0] n;
        n = {1'b0, idx} + (IW+1)'(1);
        ring_next = (32'(n) >= 32'(cap)) ? '0 : n[IW-1:0];
    endfunction

    // Entry memories: one write port, one registered read port
    logic [63:0] time_mem [DEPTH];
    logic [31:0] pay_mem  [DEPTH];
    logic [63:0] time_rd_reg;
    logic [31:0] pay_rd_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    // Control and ring state
    state_t        state_reg,        state_next;
    logic [CW-1:0] cap_reg,          cap_next;
    logic [31:0]   lag_reg,          lag_next;
    logic [CW-1:0] count_reg,        count_next;
    logic [IW-1:0] oldest_idx_reg,   oldest_idx_next;
    logic [IW-1:0] newest_idx_reg,   newest_idx_next;
    logic [63:0]   oldest_time_reg,  oldest_time_next;
    logic [63:0]   newest_time_reg,  newest_time_next;

    // Walk state
    logic [IW-1:0] scan_idx_reg,     scan_idx_next;
    logic [CW-1:0] scan_k_reg,       scan_k_next;
    logic          rd_pend_reg,      rd_pend_next;
    logic          exact_reg,        exact_next;
    logic          found_reg,        found_next;
    logic [63:0]   key_reg,          key_next;

    // Result under construction and output register
    logic [1:0]    status_reg,       status_next;
    logic [63:0]   mt_reg,           mt_next;
    logic [31:0]   mp_reg,           mp_next;
    logic          out_valid_reg,    out_valid_next;
    rsp_t          out_reg,          out_next;

    logic          req_fire;
    logic          full;
    logic          hit;
    logic [CW-1:0] cap_clamped;
    logic [IW-1:0] add_newest;
    logic [IW-1:0] add_oldest;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    assign full = (count_reg >= cap_reg);

    // A hit on the entry read last cycle; exact match keeps the oldest equal entry
    assign hit = rd_pend_reg &&
                 (exact_reg ? ((time_rd_reg == key_reg) && !found_reg)
                            : (time_rd_reg <= key_reg));

    // Capacity 0 acts as 1, anything above DEPTH as DEPTH
    always_comb
    begin
        if (cfg_data[6:0] == 7'd0)
        begin
            cap_clamped = CW'(1);
        end
        else if (int'(cfg_data[6:0]) > DEPTH)
        begin
            cap_clamped = CW'(DEPTH);
        end
        else
        begin
            cap_clamped = CW'(cfg_data[6:0]);
        end
    end

    // Ring positions after an add
    always_comb
    begin
        if (count_reg == '0)
        begin
            add_newest = '0;
            add_oldest = '0;
        end
        else if (!full)
        begin
            add_newest = ring_next(newest_idx_reg, cap_reg);
            add_oldest = oldest_idx_reg;
        end
        else
        begin
            add_newest = ring_next(newest_idx_reg, cap_reg);
            add_oldest = ring_next(oldest_idx_reg, cap_reg);
        end
    end

    // Next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        lag_next         = lag_reg;
        count_next       = count_reg;
        oldest_idx_next  = oldest_idx_reg;
        newest_idx_next  = newest_idx_reg;
        oldest_time_next = oldest_time_reg;
        newest_time_next = newest_time_reg;
        scan_idx_next    = scan_idx_reg;
        scan_k_next      = scan_k_reg;
        rd_pend_next     = 1'b0;
        exact_next       = exact_reg;
        found_next       = found_reg;
        key_next         = key_reg;
        status_next      = status_reg;
        mt_next          = mt_reg;
        mp_next          = mp_reg;
        out_valid_next   = out_valid_reg && !rsp_ready;
        out_next         = out_reg;
        mem_we           = 1'b0;
        mem_waddr        = add_newest;
        mem_re           = 1'b0;
        mem_raddr        = oldest_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    status_next = STAT_OK;
                    mt_next     = '0;
                    mp_next     = '0;
                    found_next  = 1'b0;
                    case (req_data.req_type)
                        REQ_ADD:
                        begin
                            mem_we           = 1'b1;
                            newest_idx_next  = add_newest;
                            oldest_idx_next  = add_oldest;
                            newest_time_next = req_data.time_stamp;
                            if (count_reg == '0)
                            begin
                                count_next       = CW'(1);
                                oldest_time_next = req_data.time_stamp;
                                state_next       = ST_DONE;
                            end
                            else if (!full)
                            begin
                                count_next = count_reg + CW'(1);
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                // oldest moved onto the next entry: fetch its time
                                state_next = ST_OLD_RD;
                            end
                        end
                        REQ_LOOK:
                        begin
                            if (req_data.time_stamp < {32'd0, lag_reg})
                            begin
                                status_next = STAT_BELOW_LAG;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                key_next      = req_data.time_stamp - {32'd0, lag_reg};
                                exact_next    = 1'b0;
                                scan_idx_next = oldest_idx_reg;
                                scan_k_next   = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        REQ_EXACT:
                        begin
                            key_next      = req_data.time_stamp;
                            exact_next    = 1'b1;
                            scan_idx_next = oldest_idx_reg;
                            scan_k_next   = '0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            count_next      = '0;
                            oldest_idx_next = '0;
                            newest_idx_next = '0;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_OLD_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = oldest_idx_reg;
                state_next = ST_OLD_CAP;
            end
            ST_OLD_CAP:
            begin
                oldest_time_next = time_rd_reg;
                state_next       = ST_DONE;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    mt_next    = time_rd_reg;
                    mp_next    = pay_rd_reg;
                end
                if (scan_k_reg != count_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = scan_idx_reg;
                    rd_pend_next  = 1'b1;
                    scan_idx_next = ring_next(scan_idx_reg, cap_reg);
                    scan_k_next   = scan_k_reg + CW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    status_next = found_reg ? STAT_OK : STAT_MISS;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = status_reg;
                    out_next.match_time    = mt_reg;
                    out_next.match_payload = mp_reg;
                    out_next.fill_count    = 7'(count_reg);
                    out_next.oldest_time   = (count_reg != '0) ? oldest_time_reg : 64'd0;
                    out_next.newest_time   = (count_reg != '0) ? newest_time_reg : 64'd0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must send register writes only while idle; the block itself does not enforce it
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAPACITY:
                begin
                    cap_next        = cap_clamped;
                    count_next      = '0;
                    oldest_idx_next = '0;
                    newest_idx_next = '0;
                end
                CFG_LAG:
                begin
                    lag_next = cfg_data;
                end
                default:
                begin
                    lag_next = lag_reg;
                end
            endcase
        end
    end

    // Entry memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[mem_waddr] <= req_data.time_stamp;
            pay_mem[mem_waddr]  <= req_data.item_payload;
        end
        if (mem_re)
        begin
            time_rd_reg <= time_mem[mem_raddr];
            pay_rd_reg  <= pay_mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CW'(CAP_RST_I);
            lag_reg        <= '0;
            count_reg      <= '0;
            oldest_idx_reg <= '0;
            newest_idx_reg <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            lag_reg        <= lag_next;
            count_reg      <= count_next;
            oldest_idx_reg <= oldest_idx_next;
            newest_idx_reg <= newest_idx_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        oldest_time_reg <= oldest_time_next;
        newest_time_reg <= newest_time_next;
        scan_idx_reg    <= scan_idx_next;
        scan_k_reg      <= scan_k_next;
        exact_reg       <= exact_next;
        found_reg       <= found_next;
        key_reg         <= key_next;
        status_reg      <= status_next;
        mt_reg          <= mt_next;
        mp_reg          <= mp_next;
        out_reg         <= out_next;
    end

endmodule

@@ rtl/core/trbl_checker.sv @@
// Port-level checker for the timestamp ring buffer lookup block, bound to the top level.
`include "timestamp_ring_buffer_lookup_defines.svh"

module trbl_checker #(
    parameter int DEPTH = trbl_pkg::DEPTH_DEFAULT
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input trbl_pkg::rsp_t                   rsp_data
);
    import trbl_pkg::*;

    // An empty ring reports no oldest or newest timestamp
    `TRBL_ASSERT_SAME(a_empty_times, rsp_valid && (rsp_data.fill_count == 7'd0),
        (rsp_data.oldest_time == 64'd0) && (rsp_data.newest_time == 64'd0),
        "empty ring reports nonzero boundary timestamps")

    // A single entry is both oldest and newest
    `TRBL_ASSERT_SAME(a_single_entry, rsp_valid && (rsp_data.fill_count == 7'd1),
        rsp_data.oldest_time == rsp_data.newest_time,
        "single entry ring with differing oldest and newest")

    // Miss and below-lag results carry no match
    `TRBL_ASSERT_SAME(a_miss_zero, rsp_valid &&
        ((rsp_data.status == STAT_MISS) || (rsp_data.status == STAT_BELOW_LAG)),
        (rsp_data.match_time == 64'd0) && (rsp_data.match_payload == 32'd0),
        "miss result carries match data")

    // Hold a stalled result
    `TRBL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_data),
        "stalled result dropped or changed")

    // Fill count never passes the ring depth
    `TRBL_ASSERT_SAME(a_fill_bound, rsp_valid, 32'(rsp_data.fill_count) <= DEPTH,
        "fill count above ring depth")

endmodule

bind timestamp_ring_buffer_lookup trbl_checker #(.DEPTH(DEPTH)) u_trbl_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for the timestamp ring buffer lookup block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trbl_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    // One row of the directed stimulus table: either a register write or a
    // request, optionally with the result typed in by hand.
    typedef struct {
        bit          is_reg;
        logic [1:0]  reg_index;
        logic [31:0] reg_value;
        req_t        req;
        bit          pinned;
        rsp_t        want;
    } dir_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req_data = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Hand-typed result that travels alongside the request it belongs to.
    bit          pinned_now = 1'b0;
    rsp_t        pinned_rsp = '0;

    // Shadow of the ring: contents, fill, head indexes and register settings.
    logic [63:0] ring_time [DEPTH];
    logic [31:0] ring_pay  [DEPTH];
    int unsigned ring_fill = 0;
    int unsigned ring_old  = 0;
    int unsigned ring_new  = 0;
    logic [6:0]  cap_setting = CAP_RESET;
    logic [31:0] lag_setting = '0;

    // Results owed by the block, oldest first, and a count of requests in flight.
    rsp_t        answers_due[$];
    int          in_flight = 0;
    int          mismatches = 0;

    // Stimulus-side bookkeeping: idle rates, running timestamp, recent adds.
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    logic [63:0] stamp_now = '0;
    logic [31:0] lag_now = '0;
    logic [63:0] recent_ts[$];
    dir_row_t    steps[$];

    timestamp_ring_buffer_lookup #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin
        #25ms;
        $display("FAIL");
        $finish;
    end

    // Print one line per mismatch and count every one.
    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Capacity as the ring uses it: zero acts as one, above DEPTH acts as DEPTH.
    function automatic int unsigned cap_eff();
        if (cap_setting == 7'd0)
            return 1;
        if (cap_setting > DEPTH)
            return DEPTH;
        return 32'(cap_setting);
    endfunction

    function automatic int unsigned ring_step(input int unsigned i);
        return (i + 1 >= cap_eff()) ? 0 : i + 1;
    endfunction

    function automatic void empty_ring();
        ring_fill = 0;
        ring_old  = 0;
        ring_new  = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [31:0] val);
        if (idx == CFG_CAPACITY)
        begin
            cap_setting = val[6:0];
            empty_ring();
        end
        else if (idx == CFG_LAG)
        begin
            lag_setting = val;
        end
    endfunction

    // Advance the shadow ring by one request and return the result it owes.
    function automatic rsp_t ring_answer(input req_t r);
        rsp_t        a;
        int unsigned idx;
        logic [63:0] eff;
        bit          hit;
        a = '0;
        hit = 1'b0;
        idx = ring_old;
        case (r.req_type)
            REQ_ADD:
            begin
                if (ring_fill == 0)
                begin
                    ring_old  = 0;
                    ring_new  = 0;
                    ring_fill = 1;
                end
                else if (ring_fill < cap_eff())
                begin
                    ring_new = ring_step(ring_new);
                    ring_fill++;
                end
                else
                begin
                    // Full ring: overwrite the oldest entry.
                    ring_new = ring_step(ring_new);
                    ring_old = ring_step(ring_old);
                end
                ring_time[ring_new] = r.time_stamp;
                ring_pay[ring_new]  = r.item_payload;
            end
            REQ_LOOK:
            begin
                if (r.time_stamp < {32'h0, lag_setting})
                begin
                    a.status = STAT_BELOW_LAG;
                end
                else
                begin
                    eff = r.time_stamp - {32'h0, lag_setting};
                    // Walk every valid entry; the last one not later than eff wins.
                    for (int k = 0; k < ring_fill; k++)
                    begin
                        if (ring_time[idx] <= eff)
                        begin
                            hit = 1'b1;
                            a.match_time    = ring_time[idx];
                            a.match_payload = ring_pay[idx];
                        end
                        idx = ring_step(idx);
                    end
                    a.status = hit ? STAT_OK : STAT_MISS;
                end
            end
            REQ_EXACT:
            begin
                // No lag here; the oldest equal entry is returned.
                a.status = STAT_MISS;
                for (int k = 0; k < ring_fill; k++)
                begin
                    if (!hit && ring_time[idx] == r.time_stamp)
                    begin
                        hit = 1'b1;
                        a.status        = STAT_OK;
                        a.match_time    = ring_time[idx];
                        a.match_payload = ring_pay[idx];
                    end
                    idx = ring_step(idx);
                end
            end
            default:
            begin
                empty_ring();
            end
        endcase
        a.fill_count  = 7'(ring_fill);
        a.oldest_time = (ring_fill != 0) ? ring_time[ring_old] : 64'h0;
        a.newest_time = (ring_fill != 0) ? ring_time[ring_new] : 64'h0;
        return a;
    endfunction

    // Monitor: sample all three handshakes at the edge, predict on request accept,
    // compare on result accept. All stimulus is driven by NBA, so the values
    // seen here are the ones the block saw at this edge.
    always @(posedge clk)
    begin
        rsp_t got_due;
        rsp_t owed;
        int   delta;
        delta = 0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (req_valid && req_ready)
            begin
                owed = ring_answer(req_data);
                if (pinned_now)
                    owed = pinned_rsp;
                answers_due.push_back(owed);
                delta++;
            end
            if (rsp_valid && rsp_ready)
            begin
                delta--;
                if (answers_due.size() == 0)
                begin
                    flag_mismatch("result transaction with nothing expected");
                end
                else
                begin
                    got_due = answers_due.pop_front();
                    check_field("status", 64'(rsp_data.status), 64'(got_due.status));
                    check_field("match_time", rsp_data.match_time, got_due.match_time);
                    check_field("match_payload", 64'(rsp_data.match_payload),
                                64'(got_due.match_payload));
                    check_field("fill_count", 64'(rsp_data.fill_count),
                                64'(got_due.fill_count));
                    check_field("oldest_time", rsp_data.oldest_time, got_due.oldest_time);
                    check_field("newest_time", rsp_data.newest_time, got_due.newest_time);
                end
            end
            in_flight <= in_flight + delta;
        end
    end

    // Receiver: drop ready at random at the configured stall rate.
    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) < stall_pct) ? 1'b0 : 1'b1;

    // Present one request; hold valid and payload until the transaction.
    // Valid is only lowered when an idle gap actually follows.
    task automatic send_request(input req_t r, input bit pin, input rsp_t want);
        int unsigned gap;
        gap = 0;
        while (gap < 24 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_data   <= r;
        pinned_now <= pin;
        pinned_rsp <= want;
        do @(posedge clk); while (!req_ready);
    endtask

    // Write a register only once the block has returned every result.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        req_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LAG)
            lag_now = val;
        else if (idx == CFG_CAPACITY)
            recent_ts.delete();
    endtask

    function automatic dir_row_t req_row(input logic [1:0] op, input logic [63:0] ts,
                                         input logic [31:0] pay);
        dir_row_t row;
        row.is_reg    = 1'b0;
        row.reg_index = '0;
        row.reg_value = '0;
        row.req.req_type     = op;
        row.req.time_stamp   = ts;
        row.req.item_payload = pay;
        row.pinned    = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic dir_row_t pin_row(input logic [1:0] op, input logic [63:0] ts,
                                         input logic [31:0] pay, input logic [1:0] st,
                                         input logic [63:0] mt, input logic [31:0] mp,
                                         input logic [6:0] fc, input logic [63:0] old_t,
                                         input logic [63:0] new_t);
        dir_row_t row;
        row = req_row(op, ts, pay);
        row.pinned = 1'b1;
        row.want.status        = st;
        row.want.match_time    = mt;
        row.want.match_payload = mp;
        row.want.fill_count    = fc;
        row.want.oldest_time   = old_t;
        row.want.newest_time   = new_t;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
        dir_row_t row;
        row = req_row(REQ_ADD, '0, '0);
        row.is_reg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    // Build one random request. Most are well formed: ascending adds, lookups
    // aimed just around stored stamps plus lag, exact hits on stored stamps.
    // The rest is clears, below-lag lookups and fully random noise.
    task automatic pick_request(output req_t r);
        int unsigned roll;
        logic [63:0] ref_ts;
        roll = $urandom_range(0, 99);
        ref_ts = (recent_ts.size() != 0) ?
                 recent_ts[$urandom_range(0, recent_ts.size() - 1)] : stamp_now;
        r.item_payload = $urandom;
        r.time_stamp   = stamp_now;
        if (roll < 44)
        begin
            r.req_type = REQ_ADD;
            // Step of zero makes duplicate stamps; the odd big jump spreads bits.
            if ($urandom_range(0, 19) == 0)
                stamp_now = stamp_now + {32'h0, $urandom};
            else
                stamp_now = stamp_now + $urandom_range(0, 300);
            r.time_stamp = stamp_now;
            recent_ts.push_back(stamp_now);
        end
        else if (roll < 70)
        begin
            r.req_type = REQ_LOOK;
            case ($urandom_range(0, 7))
                0, 1:    r.time_stamp = ref_ts + {32'h0, lag_now};
                2:       r.time_stamp = ref_ts + {32'h0, lag_now} - 64'd1;
                3, 4:    r.time_stamp = ref_ts + {32'h0, lag_now} + $urandom_range(0, 500);
                5:       r.time_stamp = stamp_now + {32'h0, lag_now} + $urandom_range(0, 50);
                6:       r.time_stamp = ref_ts + {32'h0, lag_now} - $urandom_range(1, 2000);
                default: r.time_stamp = (lag_now != 0) ?
                                        {32'h0, $urandom_range(0, lag_now - 1)} :
                                        {$urandom, $urandom};
            endcase
        end
        else if (roll < 90)
        begin
            r.req_type = REQ_EXACT;
            case ($urandom_range(0, 4))
                0:       r.time_stamp = ref_ts + 64'd1;
                1:       r.time_stamp = ref_ts - 64'd1;
                default: r.time_stamp = ref_ts;
            endcase
        end
        else if (roll < 92)
        begin
            r.req_type   = REQ_CLEAR;
            r.time_stamp = {$urandom, $urandom};
            recent_ts.delete();
        end
        else
        begin
            // Noise: any operation with a fully random stamp.
            r.req_type   = 2'($urandom_range(0, 3));
            r.time_stamp = {$urandom, $urandom};
            if (r.req_type == REQ_ADD)
                recent_ts.push_back(r.time_stamp);
            else if (r.req_type == REQ_CLEAR)
                recent_ts.delete();
        end
        if (recent_ts.size() > DEPTH)
            void'(recent_ts.pop_front());
    endtask

    // Main sequence: reset, directed table, then phases of random traffic.
    initial
    begin
        logic [6:0]  cap_plan [8];
        logic [31:0] lag_plan [8];
        logic [31:0] word;
        req_t        r;
        dir_row_t    row;
        localparam logic [63:0] ONES = '1;
        localparam logic [63:0] T1 = 64'h1_0000_0000;
        localparam logic [63:0] T2 = 64'h1_0000_0005;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty ring, the field extremes, clear, below-lag, a
        // one-entry ring with capacity zero, clamped capacity, unknown
        // register indexes, unordered stamps and duplicate stamps.
        steps.push_back(pin_row(REQ_LOOK, 64'h0, 32'h0, STAT_MISS, 0, 0, 0, 0, 0));
        steps.push_back(pin_row(REQ_EXACT, ONES, 32'hFFFF_FFFF, STAT_MISS, 0, 0, 0, 0, 0));
        steps.push_back(pin_row(REQ_ADD, 64'h0, 32'h0, STAT_OK, 0, 0, 1, 0, 0));
        steps.push_back(pin_row(REQ_ADD, 64'h10, 32'hFFFF_FFFF, STAT_OK, 0, 0, 2, 0, 64'h10));
        steps.push_back(pin_row(REQ_LOOK, 64'hF, 32'h1, STAT_OK, 0, 0, 2, 0, 64'h10));
        steps.push_back(pin_row(REQ_LOOK, 64'h10, 32'h0, STAT_OK, 64'h10, 32'hFFFF_FFFF,
                                2, 0, 64'h10));
        steps.push_back(pin_row(REQ_EXACT, 64'h10, 32'h0, STAT_OK, 64'h10, 32'hFFFF_FFFF,
                                2, 0, 64'h10));
        steps.push_back(pin_row(REQ_EXACT, 64'h11, 32'h0, STAT_MISS, 0, 0, 2, 0, 64'h10));
        steps.push_back(pin_row(REQ_ADD, ONES, 32'hA5A5_5A5A, STAT_OK, 0, 0, 3, 0, ONES));
        steps.push_back(pin_row(REQ_LOOK, ONES, 32'h0, STAT_OK, ONES, 32'hA5A5_5A5A,
                                3, 0, ONES));
        steps.push_back(pin_row(REQ_CLEAR, 64'h1234, 32'hDEAD_BEEF, STAT_OK, 0, 0, 0, 0, 0));
        // Capacity zero acts as one; upper data bits are ignored.
        steps.push_back(reg_row(CFG_CAPACITY, 32'hFFFF_FF80));
        steps.push_back(reg_row(CFG_LAG, 32'hFFFF_FFFF));
        steps.push_back(pin_row(REQ_LOOK, 64'hFFFF_FFFE, 32'h0, STAT_BELOW_LAG,
                                0, 0, 0, 0, 0));
        steps.push_back(pin_row(REQ_ADD, T1, 32'h1, STAT_OK, 0, 0, 1, T1, T1));
        steps.push_back(pin_row(REQ_ADD, T2, 32'h2, STAT_OK, 0, 0, 1, T2, T2));
        steps.push_back(pin_row(REQ_LOOK, 64'h1_FFFF_FFFF, 32'h0, STAT_MISS,
                                0, 0, 1, T2, T2));
        steps.push_back(pin_row(REQ_LOOK, 64'h2_0000_0004, 32'h0, STAT_OK,
                                T2, 32'h2, 1, T2, T2));
        steps.push_back(pin_row(REQ_LOOK, 64'hFFFF_FFFF, 32'h0, STAT_MISS,
                                0, 0, 1, T2, T2));
        // Above DEPTH clamps to DEPTH; the write empties the ring.
        steps.push_back(reg_row(CFG_CAPACITY, 32'h0000_007F));
        steps.push_back(reg_row(CFG_LAG, 32'h0));
        steps.push_back(reg_row(2'd2, 32'h5555_AAAA));
        steps.push_back(reg_row(2'd3, 32'hAAAA_5555));
        steps.push_back(req_row(REQ_ADD, 64'd100, 32'h7));
        steps.push_back(req_row(REQ_ADD, 64'd50, 32'h8));
        steps.push_back(req_row(REQ_ADD, 64'd50, 32'h9));
        steps.push_back(req_row(REQ_LOOK, 64'd60, 32'h0));
        steps.push_back(req_row(REQ_EXACT, 64'd50, 32'h0));

        foreach (steps[i])
        begin
            row = steps[i];
            if (row.is_reg)
                write_reg(row.reg_index, row.reg_value);
            else
                send_request(row.req, row.pinned, row.want);
        end

        // Random phases: cycle through the idle modes twice, each phase with
        // its own capacity and lag, extremes included.
        cap_plan = '{7'd64, 7'd1, 7'd3, 7'd0, 7'd100, 7'($urandom_range(1, 64)),
                     7'd2, 7'd127};
        lag_plan = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'($urandom_range(0, 2000)),
                     32'h0, $urandom, 32'h1, 32'h0};
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_pct  = (ph % 4 == 1) ? 61 : (ph % 4 == 3) ? 28 : 0;
            stall_pct = (ph % 4 == 2) ? 61 : (ph % 4 == 3) ? 28 : 0;
            word = $urandom;
            word[6:0] = cap_plan[ph];
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(CFG_LAG, lag_plan[ph]);
                write_reg(CFG_CAPACITY, word);
            end
            else
            begin
                write_reg(CFG_CAPACITY, word);
                write_reg(CFG_LAG, lag_plan[ph]);
            end
            if ($urandom_range(0, 1) != 0)
                write_reg(2'($urandom_range(2, 3)), $urandom);

            // Start stamps low, anywhere, or close to the top so they wrap.
            case (ph % 3)
                0:       stamp_now = {32'h0, 32'($urandom_range(0, 1000))};
                1:       stamp_now = {$urandom, $urandom};
                default: stamp_now = {32'hFFFF_FFFF, 32'hFFFF_0000 | $urandom_range(0, 65535)};
            endcase
            recent_ts.delete();

            for (int n = 0; n < 210; n++)
            begin
                pick_request(r);
                send_request(r, 1'b0, '0);
            end
        end

        // Drain: wait for every owed result, bounded, then let the block settle.
        req_valid <= 1'b0;
        for (int w = 0; w < 200000 && in_flight != 0; w++)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (answers_due.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", answers_due.size()));

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/trbl_pkg.sv
rtl/core/timestamp_ring_buffer_lookup.sv
rtl/core/trbl_checker.sv
bench/tb.sv
